FILE: design/twc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_pkg: shared types, codes and tables for the triangle wave channel
// Field widths, action and register codes, the length table and the
// sequence level map.
// ----------------------------------------------------------------------------
package twc_pkg;

    localparam int ACTION_W = 3;
    localparam int ADDR_W   = 2;
    localparam int DATA_W   = 8;
    localparam int LEVEL_W  = 4;
    localparam int STEPS_W  = 2;
    localparam int PERIOD_W = 11;
    localparam int DIV_W    = 12;
    localparam int LEN_W    = 8;
    localparam int LIN_W    = 7;
    localparam int SEQ_W    = 5;
    localparam int LEN_IDX_W = 5;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_REG_WRITE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ENABLE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STATUS    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_QUARTER   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_HALF      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd5;

    // Channel register indexes
    localparam logic [ADDR_W-1:0] REG_LINEAR    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_UNUSED    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_PERIOD_LO = 2'd2;
    localparam logic [ADDR_W-1:0] REG_PERIOD_HI = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   reg_address;
        logic [DATA_W-1:0]   write_data;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [STEPS_W-1:0] steps_taken;
        logic               status_bit;
    } result_t;

    function automatic logic [LEN_W-1:0] length_lookup(input logic [LEN_IDX_W-1:0] idx);
        logic [LEN_W-1:0] val;
        case (idx)
            5'd0:    val = 8'd10;
            5'd1:    val = 8'd254;
            5'd2:    val = 8'd20;
            5'd3:    val = 8'd2;
            5'd4:    val = 8'd40;
            5'd5:    val = 8'd4;
            5'd6:    val = 8'd80;
            5'd7:    val = 8'd6;
            5'd8:    val = 8'd160;
            5'd9:    val = 8'd8;
            5'd10:   val = 8'd60;
            5'd11:   val = 8'd10;
            5'd12:   val = 8'd14;
            5'd13:   val = 8'd12;
            5'd14:   val = 8'd26;
            5'd15:   val = 8'd14;
            5'd16:   val = 8'd12;
            5'd17:   val = 8'd16;
            5'd18:   val = 8'd24;
            5'd19:   val = 8'd18;
            5'd20:   val = 8'd48;
            5'd21:   val = 8'd20;
            5'd22:   val = 8'd96;
            5'd23:   val = 8'd22;
            5'd24:   val = 8'd192;
            5'd25:   val = 8'd24;
            5'd26:   val = 8'd72;
            5'd27:   val = 8'd26;
            5'd28:   val = 8'd16;
            5'd29:   val = 8'd28;
            5'd30:   val = 8'd32;
            default: val = 8'd30;
        endcase
        return val;
    endfunction

    // Up ramp on the first half, mirrored down ramp on the second half
    function automatic logic [LEVEL_W-1:0] level_of(input logic [SEQ_W-1:0] pos);
        return pos[SEQ_W-1] ? ~pos[LEVEL_W-1:0] : pos[LEVEL_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/twc_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_cmd_if: action channel of the triangle wave channel
// Valid/ready handshake carrying one action item.
// ----------------------------------------------------------------------------
interface twc_cmd_if;
    import twc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   reg_address;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, action, reg_address, write_data, input ready);
    modport sink   (input valid, action, reg_address, write_data, output ready);
endinterface
`default_nettype wire

FILE: design/twc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_rsp_if: result channel of the triangle wave channel
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface twc_rsp_if;
    import twc_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic [STEPS_W-1:0] steps_taken;
    logic               status_bit;

    modport source (output valid, level, steps_taken, status_bit, input ready);
    modport sink   (input valid, level, steps_taken, status_bit, output ready);
endinterface
`default_nettype wire

FILE: design/twc_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_in_stage: input register
// Captures one action item and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module twc_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    twc_cmd_if.sink            cmd,
    input  wire logic          advance,
    output logic               pending,
    output twc_pkg::item_t     item
);
    import twc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign cmd.ready = !valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action      <= cmd.action;
            item_reg.reg_address <= cmd.reg_address;
            item_reg.write_data  <= cmd.write_data;
        end
    end

    assign pending = valid_reg;
    assign item    = item_reg;

endmodule
`default_nettype wire

FILE: design/twc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_core: channel state and per-item update
// Holds period, length, linear counter, divider and sequence position, and
// applies one action per fire, producing the result of that action.
// ----------------------------------------------------------------------------
module twc_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire twc_pkg::item_t item,
    output twc_pkg::result_t   result
);
    import twc_pkg::*;

    logic [LIN_W-1:0]    lin_reload_reg,  lin_reload_next;
    logic                hold_reg,        hold_next;
    logic [PERIOD_W-1:0] period_reg,      period_next;
    logic [LEN_W-1:0]    length_reg,      length_next;
    logic                reload_reg,      reload_next;
    logic [LIN_W-1:0]    linear_reg,      linear_next;
    logic [DIV_W-1:0]    divider_reg,     divider_next;
    logic [SEQ_W-1:0]    seq_reg,         seq_next;
    logic                enabled_reg,     enabled_next;
    logic                latch_reg,       latch_next;
    logic [LEVEL_W-1:0]  level_reg,       level_next;
    logic [STEPS_W-1:0]  steps;
    logic                live;

    assign live = (linear_reg != '0) && (length_reg != '0) && enabled_reg;

    always_comb
    begin
        lin_reload_next = lin_reload_reg;
        hold_next       = hold_reg;
        period_next     = period_reg;
        length_next     = length_reg;
        reload_next     = reload_reg;
        linear_next     = linear_reg;
        divider_next    = divider_reg;
        seq_next        = seq_reg;
        enabled_next    = enabled_reg;
        latch_next      = latch_reg;
        level_next      = level_reg;
        steps           = '0;

        if (fire)
        begin
            unique case (item.action)
                ACT_REG_WRITE:
                begin
                    unique case (item.reg_address)
                        REG_LINEAR:
                        begin
                            lin_reload_next = item.write_data[LIN_W-1:0];
                            hold_next       = item.write_data[DATA_W-1];
                        end
                        REG_PERIOD_LO:
                        begin
                            period_next[DATA_W-1:0] = item.write_data;
                        end
                        REG_PERIOD_HI:
                        begin
                            period_next[PERIOD_W-1:DATA_W] =
                                item.write_data[PERIOD_W-DATA_W-1:0];
                            length_next = length_lookup(
                                item.write_data[DATA_W-1:DATA_W-LEN_IDX_W]);
                            reload_next = 1'b1;
                            if (latch_reg)
                            begin
                                enabled_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused register: drop the write
                        end
                    endcase
                end
                ACT_ENABLE:
                begin
                    latch_next = item.write_data[0];
                    if (!item.write_data[0])
                    begin
                        enabled_next = 1'b0;
                    end
                end
                ACT_QUARTER:
                begin
                    if (reload_reg)
                    begin
                        linear_next = lin_reload_reg;
                    end
                    else if (linear_reg != '0)
                    begin
                        linear_next = linear_reg - LIN_W'(1);
                    end
                    if (!hold_reg)
                    begin
                        reload_next = 1'b0;
                    end
                end
                ACT_HALF:
                begin
                    if (!hold_reg && (length_reg != '0))
                    begin
                        length_next = length_reg - LEN_W'(1);
                    end
                end
                ACT_TICK:
                begin
                    if (live)
                    begin
                        if (divider_reg == '0)
                        begin
                            if (period_reg == '0)
                            begin
                                // cleared divider and zero period: step twice
                                level_next   = level_of(seq_reg + SEQ_W'(1));
                                seq_next     = seq_reg + SEQ_W'(2);
                                divider_next = DIV_W'(1);
                                steps        = STEPS_W'(2);
                            end
                            else
                            begin
                                level_next   = level_of(seq_reg);
                                seq_next     = seq_reg + SEQ_W'(1);
                                divider_next = DIV_W'(period_reg);
                                steps        = STEPS_W'(1);
                            end
                        end
                        else if (divider_reg == DIV_W'(1))
                        begin
                            level_next   = level_of(seq_reg);
                            seq_next     = seq_reg + SEQ_W'(1);
                            divider_next = DIV_W'(period_reg) + DIV_W'(1);
                            steps        = STEPS_W'(1);
                        end
                        else
                        begin
                            divider_next = divider_reg - DIV_W'(1);
                        end
                    end
                end
                default:
                begin
                    // status read and unknown actions change nothing
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reload_reg <= '0;
            hold_reg       <= 1'b0;
            period_reg     <= '0;
            length_reg     <= '0;
            reload_reg     <= 1'b0;
            linear_reg     <= '0;
            divider_reg    <= '0;
            seq_reg        <= '0;
            enabled_reg    <= 1'b0;
            latch_reg      <= 1'b0;
            level_reg      <= '0;
        end
        else
        begin
            lin_reload_reg <= lin_reload_next;
            hold_reg       <= hold_next;
            period_reg     <= period_next;
            length_reg     <= length_next;
            reload_reg     <= reload_next;
            linear_reg     <= linear_next;
            divider_reg    <= divider_next;
            seq_reg        <= seq_next;
            enabled_reg    <= enabled_next;
            latch_reg      <= latch_next;
            level_reg      <= level_next;
        end
    end

    assign result.level       = level_next;
    assign result.steps_taken = steps;
    assign result.status_bit  = (length_next != '0) && enabled_next;

endmodule
`default_nettype wire

FILE: design/twc_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_out_stage: result register
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module twc_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire twc_pkg::result_t result,
    output logic                 free,
    twc_rsp_if.source            rsp
);
    import twc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.level       = result_reg.level;
    assign rsp.steps_taken = result_reg.steps_taken;
    assign rsp.status_bit  = result_reg.status_bit;

endmodule
`default_nettype wire

FILE: design/triangle_wave_channel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_wave_channel: triangle sound channel
// Register writes, enable, status, frame clocks and ticks in; level, step
// count and status out, one result item per action item.
//
//   port  role    payload
//   cmd   sink    action, reg_address, write_data
//   rsp   source  level, steps_taken, status_bit
//
// One item per cycle sustained while rsp is ready; a result item becomes valid
// on rsp once its action item has passed from cmd through the input register
// and, with the state update, into the result register.
// The channel state updates in the same cycle an item moves from the input
// register to the result register.
// Reset clears all channel state and both stage valids.
// A stall on rsp holds the result register; cmd keeps accepting until the
// input register is also full.
// ----------------------------------------------------------------------------
module triangle_wave_channel (
    input  wire logic  clk,
    input  wire logic  rst_n,
    twc_cmd_if.sink    cmd,
    twc_rsp_if.source  rsp
);
    import twc_pkg::*;

    logic    pending;
    logic    free;
    logic    advance;
    item_t   item;
    result_t result;

    assign advance = pending && free;

    twc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .advance (advance),
        .pending (pending),
        .item    (item)
    );

    twc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (result)
    );

    twc_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .free   (free),
        .rsp    (rsp)
    );

endmodule
`default_nettype wire
